/* src/pfe_pkg.sv */
//==============================================================================
// pfe_pkg
// Word types, status codes and character codes of the postfix evaluator.
//==============================================================================
`default_nettype none

package pfe_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [2:0]         status;
        logic [4:0]         items_left;
    } t_out_word;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_DIVZ    = 3'd3;
    localparam logic [2:0] ST_BADCHAR = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

endpackage

`default_nettype wire

/* src/postfix_expression_evaluator.sv */
//==============================================================================
// postfix_expression_evaluator
// Evaluates a postfix expression streamed one character word at a time.
//==============================================================================
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_stall    | pfe_pkg::t_in_word
//  out     | output    | o_out_valid / i_out_stall  | pfe_pkg::t_out_word
//
//  Digit, + and -: accept, execute and finish steps; * and / add a shift-add
//  multiplier or restoring divider pass before finish; errors go straight to finish.
//  The stack sits in a one-port-write synchronous memory; the top entry is a
//  register, so an operator reads one operand from memory.
//  Reset clears state, pointer, error and output valid; no clearing pass on the memory.
//  A last word waits in the finish step while a previous result is stalled.
//==============================================================================
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire pfe_pkg::t_in_word   i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output pfe_pkg::t_out_word       o_out_data
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = $clog2(VALUE_WIDTH);
    localparam int W   = VALUE_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [W-1:0] r_mem [STACK_DEPTH];

    logic [2:0]     r_state, n_state;
    logic [SPW-1:0] r_sp, n_sp;
    logic [2:0]     r_err, n_err;
    logic [W-1:0]   r_top, n_top;
    logic [7:0]     r_char;
    logic           r_last;
    logic [W-1:0]   r_rd;
    logic [W-1:0]   r_acc, n_acc;
    logic [W-1:0]   r_opa, n_opa;
    logic [W-1:0]   r_opb, n_opb;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_neg, n_neg;
    logic           r_out_valid, n_out_valid;
    pfe_pkg::t_out_word r_out, n_out;

    logic           accept;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;
    logic [W-1:0]   mul_sum;
    logic [W:0]     div_shift;
    logic [W:0]     div_diff;
    logic [W-1:0]   div_rem;
    logic [W-1:0]   div_quo;
    logic [W-1:0]   div_res;
    logic [2:0]     fin_status;
    logic signed [W-1:0] top_s;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign raddr      = AW'(r_sp - SPW'(2));

    assign mul_sum   = r_acc + (r_opb[0] ? r_opa : '0);
    assign div_shift = {r_acc, r_opa[W-1]};
    assign div_diff  = div_shift - {1'b0, r_opb};
    assign div_rem   = div_diff[W] ? div_shift[W-1:0] : div_diff[W-1:0];
    assign div_quo   = {r_opa[W-2:0], !div_diff[W]};
    assign div_res   = r_neg ? (W'(0) - div_quo) : div_quo;
    assign top_s     = r_top;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= r_top;
        end
        if (accept) begin
            r_rd   <= r_mem[raddr];
            r_char <= i_in_data.char_code;
            r_last <= i_in_data.is_last;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_err       = r_err;
        n_top       = r_top;
        n_acc       = r_acc;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = AW'(r_sp - SPW'(1));
        fin_status  = r_err;
        if (r_err == pfe_pkg::ST_OK && r_sp == '0) begin
            fin_status = pfe_pkg::ST_UNDER;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (r_err == pfe_pkg::ST_OK) begin
                    if (r_char inside {[pfe_pkg::CH_ZERO:pfe_pkg::CH_NINE]}) begin
                        if (r_sp >= SPW'(STACK_DEPTH)) begin
                            n_err = pfe_pkg::ST_OVER;
                        end else begin
                            we    = (r_sp != '0);
                            n_top = W'(r_char - pfe_pkg::CH_ZERO);
                            n_sp  = r_sp + SPW'(1);
                        end
                    end else if (!(r_char inside {pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS,
                                                  pfe_pkg::CH_TIMES, pfe_pkg::CH_SLASH})) begin
                        n_err = pfe_pkg::ST_BADCHAR;
                    end else if (r_sp < SPW'(2)) begin
                        n_err = pfe_pkg::ST_UNDER;
                    end else begin
                        case (r_char)
                            pfe_pkg::CH_PLUS: begin
                                n_top = r_rd + r_top;
                                n_sp  = r_sp - SPW'(1);
                            end
                            pfe_pkg::CH_MINUS: begin
                                n_top = r_rd - r_top;
                                n_sp  = r_sp - SPW'(1);
                            end
                            pfe_pkg::CH_TIMES: begin
                                n_acc   = '0;
                                n_opa   = r_rd;
                                n_opb   = r_top;
                                n_cnt   = '0;
                                n_state = S_MUL;
                            end
                            default: begin
                                if (r_top == '0) begin
                                    n_err = pfe_pkg::ST_DIVZ;
                                end else begin
                                    n_acc   = '0;
                                    n_opa   = r_rd[W-1] ? (W'(0) - r_rd) : r_rd;
                                    n_opb   = r_top[W-1] ? (W'(0) - r_top) : r_top;
                                    n_neg   = r_rd[W-1] ^ r_top[W-1];
                                    n_cnt   = '0;
                                    n_state = S_DIV;
                                end
                            end
                        endcase
                    end
                end
            end
            S_MUL: begin
                n_acc = mul_sum;
                n_opa = {r_opa[W-2:0], 1'b0};
                n_opb = {1'b0, r_opb[W-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_top   = mul_sum;
                    n_sp    = r_sp - SPW'(1);
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                n_acc = div_rem;
                n_opa = div_quo;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_top   = div_res;
                    n_sp    = r_sp - SPW'(1);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = fin_status;
                    n_out.items_left = 5'(r_sp);
                    n_out.top_value  = (fin_status == pfe_pkg::ST_OK) ? 32'(top_s) : '0;
                    n_sp             = '0;
                    n_err            = pfe_pkg::ST_OK;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_err       <= pfe_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_top <= n_top;
        r_acc <= n_acc;
        r_opa <= n_opa;
        r_opb <= n_opb;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* bench/postfix_expression_evaluator_test.sv */
//==============================================================================
// postfix_expression_evaluator_test
// Streams postfix expressions into the evaluator, predicts each result with
// an independent stack model and checks every output word field by field.
// Runs directed cases, then random well-formed, broken, overflowing and noise
// expressions under three idling patterns and one long output hold-off.
//==============================================================================
module postfix_expression_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH_MAX    = 16;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_ITEMS  = 530;
    localparam logic [7:0]  CH_BAD_LOW   = 8'h00;
    localparam logic [7:0]  CH_BAD_HIGH  = 8'hFF;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    pfe_pkg::t_in_word   i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    pfe_pkg::t_out_word  o_out_data;

    postfix_expression_evaluator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    pfe_pkg::t_in_word   pending_words[$];
    pfe_pkg::t_out_word  expected_results[$];
    logic [7:0]          expr_chars[$];
    int                  items_added;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    bit                  hold_req = 1'b0;
    int                  mismatch_count = 0;

    // stack model
    logic signed [31:0] calc_stack[DEPTH_MAX];
    int                 calc_depth = 0;
    logic [2:0]         calc_err   = pfe_pkg::ST_OK;

    function automatic logic [7:0] dig(int n);
        return pfe_pkg::CH_ZERO + 8'(n);
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return pfe_pkg::CH_PLUS;
            1: return pfe_pkg::CH_MINUS;
            2: return pfe_pkg::CH_TIMES;
            default: return pfe_pkg::CH_SLASH;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic evaluate_word(pfe_pkg::t_in_word w);
        logic signed [31:0] opa, opb, val;
        longint             quot;
        pfe_pkg::t_out_word res;
        bit                 is_op;
        if (calc_err == pfe_pkg::ST_OK) begin
            is_op = (w.char_code == pfe_pkg::CH_PLUS) || (w.char_code == pfe_pkg::CH_MINUS) ||
                    (w.char_code == pfe_pkg::CH_TIMES) || (w.char_code == pfe_pkg::CH_SLASH);
            if (w.char_code >= pfe_pkg::CH_ZERO && w.char_code <= pfe_pkg::CH_NINE) begin
                if (calc_depth >= DEPTH_MAX) begin
                    calc_err = pfe_pkg::ST_OVER;
                end else begin
                    calc_stack[calc_depth] = 32'(w.char_code - pfe_pkg::CH_ZERO);
                    calc_depth++;
                end
            end else if (!is_op) begin
                calc_err = pfe_pkg::ST_BADCHAR;
            end else if (calc_depth < 2) begin
                calc_err = pfe_pkg::ST_UNDER;
            end else begin
                opb = calc_stack[calc_depth - 1];
                opa = calc_stack[calc_depth - 2];
                val = '0;
                case (w.char_code)
                    pfe_pkg::CH_PLUS:  val = opa + opb;
                    pfe_pkg::CH_MINUS: val = opa - opb;
                    pfe_pkg::CH_TIMES: val = opa * opb;
                    default: begin
                        if (opb == 0) begin
                            calc_err = pfe_pkg::ST_DIVZ;
                        end else begin
                            quot = longint'(opa) / longint'(opb);
                            val  = quot[31:0];
                        end
                    end
                endcase
                if (calc_err == pfe_pkg::ST_OK) begin
                    calc_stack[calc_depth - 2] = val;
                    calc_depth--;
                end
            end
        end
        if (w.is_last) begin
            res.status = calc_err;
            if (res.status == pfe_pkg::ST_OK && calc_depth == 0) begin
                res.status = pfe_pkg::ST_UNDER;
            end
            res.top_value  = (res.status == pfe_pkg::ST_OK) ? calc_stack[calc_depth - 1] : '0;
            res.items_left = 5'(calc_depth);
            expected_results.push_back(res);
            calc_depth = 0;
            calc_err   = pfe_pkg::ST_OK;
        end
    endtask

    task automatic close_expr();
        pfe_pkg::t_in_word w;
        foreach (expr_chars[i]) begin
            w.char_code = expr_chars[i];
            w.is_last   = (i == expr_chars.size() - 1);
            pending_words.push_back(w);
        end
        items_added += expr_chars.size();
        expr_chars.delete();
    endtask

    task automatic build_wellformed(int max_operands);
        int operands, digits_left, ops_left, depth;
        operands    = $urandom_range(1, max_operands);
        digits_left = operands;
        ops_left    = operands - 1;
        depth       = 0;
        if ($urandom_range(0, 7) == 0) begin
            ops_left = $urandom_range(0, ops_left);
        end
        while (digits_left > 0 || ops_left > 0) begin
            if (depth >= 2 && ops_left > 0 && (digits_left == 0 || $urandom_range(0, 1))) begin
                expr_chars.push_back(rand_op());
                depth--;
                ops_left--;
            end else begin
                expr_chars.push_back(dig($urandom_range(0, 9)));
                depth++;
                digits_left--;
            end
        end
    endtask

    task automatic add_random_expr();
        int pick, pos;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            build_wellformed(($urandom_range(0, 9) == 0) ? DEPTH_MAX : 8);
        end else if (pick < 77) begin
            build_wellformed(8);
            pos = $urandom_range(0, expr_chars.size() - 1);
            if ($urandom_range(0, 1)) begin
                expr_chars[pos] = 8'($urandom_range(0, 255));
            end else begin
                expr_chars.insert(pos, rand_op());
            end
        end else if (pick < 87) begin
            repeat ($urandom_range(1, 5)) expr_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(15, 18)) expr_chars.push_back(dig($urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
                expr_chars.push_back(rand_op());
            end
        end
        close_expr();
    endtask

    task automatic add_min_div_neg_one();
        expr_chars.push_back(dig(2));
        repeat (30) begin
            expr_chars.push_back(dig(2));
            expr_chars.push_back(pfe_pkg::CH_TIMES);
        end
        expr_chars.push_back(dig(0));
        expr_chars.push_back(dig(1));
        expr_chars.push_back(pfe_pkg::CH_MINUS);
        expr_chars.push_back(pfe_pkg::CH_SLASH);
        close_expr();
    endtask

    task automatic add_directed();
        expr_chars = {dig(0), dig(9), pfe_pkg::CH_PLUS};                    close_expr();
        expr_chars = {dig(3), dig(5), pfe_pkg::CH_MINUS};                   close_expr();
        expr_chars = {dig(9), dig(9), pfe_pkg::CH_TIMES};                   close_expr();
        expr_chars = {dig(0), dig(7), pfe_pkg::CH_MINUS, dig(2), pfe_pkg::CH_SLASH};
        close_expr();
        expr_chars = {dig(4), dig(0), pfe_pkg::CH_SLASH};                   close_expr();
        expr_chars = {pfe_pkg::CH_PLUS};                                    close_expr();
        expr_chars = {dig(1), CH_BAD_HIGH};                                 close_expr();
        expr_chars = {CH_BAD_LOW, dig(5)};                                  close_expr();
        expr_chars = {dig(1), dig(2), dig(3)};                              close_expr();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                evaluate_word(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off
    int hold_left  = 0;
    bit hold_taken = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        pfe_pkg::t_out_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with none expected");
            end else begin
                exp_word = expected_results.pop_front();
                if (o_out_data.top_value !== exp_word.top_value) begin
                    report_mismatch($sformatf("top_value %0d, expected %0d",
                                              o_out_data.top_value, exp_word.top_value));
                end
                if (o_out_data.status !== exp_word.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_out_data.status, exp_word.status));
                end
                if (o_out_data.items_left !== exp_word.items_left) begin
                    report_mismatch($sformatf("items_left %0d, expected %0d",
                                              o_out_data.items_left, exp_word.items_left));
                end
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 16;
                    hold_req      = 1'b1;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            items_added = 0;
            if (phase == 0) begin
                add_directed();
            end
            add_min_div_neg_one();
            while (items_added < PHASE_ITEMS) add_random_expr();
            while (pending_words.size() > 0 || i_in_valid || expected_results.size() > 0) begin
                @(negedge i_clk);
            end
        end
        repeat (100) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
